// ===== design/qdws_pkg.sv =====
// ----------------------------------------------------------------------------
// qdws_pkg
// Shared types and constants for the quadrature decoder with speed readout.
// ----------------------------------------------------------------------------
package qdws_pkg;

    localparam int TIME_W   = 32;
    localparam int POS_W    = 32;
    localparam int SPEED_W  = 32;
    localparam int WIN_W    = 16;
    localparam int DIV_W    = WIN_W + 1;
    localparam int DIFF_W   = POS_W + 1;
    localparam int PROD_W   = DIFF_W + 12;
    localparam int MAG_W    = 43;
    localparam int STEP_W   = 6;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [WIN_W-1:0]      TIME_DELTA_RST = 16'd100;
    localparam logic signed [11:0]    SPEED_SCALE    = 12'sd2000;
    localparam logic [STEP_W-1:0]     DIV_LAST       = STEP_W'(MAG_W - 1);
    localparam logic                  REG_TIME_DELTA = 1'b0;

    localparam logic                  OP_SAMPLE = 1'b0;
    localparam logic                  OP_CLEAR  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ABS,
        S_DIV,
        S_SAT,
        S_HOLD
    } t_state;

endpackage

// ===== design/qdws_if.sv =====
// ----------------------------------------------------------------------------
// qdws_in_if / qdws_out_if
// Valid/ready channels for encoder samples and decoded results.
// ----------------------------------------------------------------------------
interface qdws_in_if;
    import qdws_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic              pin_a;
    logic              pin_b;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output op, output pin_a, output pin_b,
                    output now_ms, input ready);
    modport sink   (input valid, input op, input pin_a, input pin_b,
                    input now_ms, output ready);
endinterface

interface qdws_out_if;
    import qdws_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [POS_W-1:0]   position;
    logic                      clockwise;
    logic signed [SPEED_W-1:0] speed;

    modport source (output valid, output position, output clockwise,
                    output speed, input ready);
    modport sink   (input valid, input position, input clockwise,
                    input speed, output ready);
endinterface

// ===== design/quadrature_decoder_with_speed_core.sv =====
// ----------------------------------------------------------------------------
// quadrature_decoder_with_speed_core
// Quadrature step counter with windowed, rounded counts-per-second readout.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one transfer per encoder sample (op = sample) or a position
//   clear (op = clear). Each transfer gives exactly one transfer on o_res with
//   the position, direction and latest speed after that item.
//   The window length sits in one APB register at byte address 0; writes
//   complete with no wait states, reads return the current value.
// Sequence:
//   An item that does not close a speed window goes from S_IDLE to S_HOLD,
//   which loads the output register. An item that closes a window passes
//   S_MUL (one multiply), S_ABS (one sign fold), S_DIV (43 restoring divide
//   steps of a single shared subtractor) and S_SAT (saturation) before
//   S_HOLD loads the output. A new item is taken only in S_IDLE; i_in is
//   not ready meanwhile.
// Reset:
//   Synchronous, active low: position, direction, window state and speed go
//   to zero, the window length to 100 ms, and no result is pending.
// Stall:
//   A finished result waits in the output register; the block takes the next
//   item meanwhile and holds its result until the register is free.
// ----------------------------------------------------------------------------
module quadrature_decoder_with_speed_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    qdws_in_if.sink                         i_in,
    qdws_out_if.source                      o_res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [qdws_pkg::PADDR_W-1:0]    paddr,
    input  logic [qdws_pkg::PDATA_W-1:0]    pwdata,
    output logic [qdws_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);
    import qdws_pkg::*;

    t_state                     r_state, n_state;
    logic [WIN_W-1:0]           r_time_delta;
    logic [POS_W-1:0]           r_cnt, n_cnt;
    logic                       r_prev_a, n_prev_a;
    logic                       r_dir, n_dir;
    logic [TIME_W-1:0]          r_win_start, n_win_start;
    logic [POS_W-1:0]           r_pos_old, n_pos_old;
    logic [POS_W-1:0]           r_pos_new, n_pos_new;
    logic [SPEED_W-1:0]         r_rate, n_rate;

    logic signed [PROD_W-1:0]   r_prod, n_prod;
    logic                       r_neg, n_neg;
    logic [MAG_W-1:0]           r_acc, n_acc;
    logic [DIV_W-1:0]           r_rem, n_rem;
    logic [DIV_W-1:0]           r_div, n_div;
    logic [STEP_W-1:0]          r_step, n_step;

    logic                       r_out_valid, n_out_valid;
    logic [POS_W-1:0]           r_out_pos, n_out_pos;
    logic                       r_out_cw, n_out_cw;
    logic [SPEED_W-1:0]         r_out_speed, n_out_speed;

    logic [WIN_W-1:0]           win_len;
    logic [TIME_W-1:0]          elapsed;
    logic signed [DIFF_W-1:0]   w_diff;
    logic [PROD_W-1:0]          prod_mag;
    logic [DIV_W:0]             rem_sh;
    logic [DIV_W+1:0]           trial;
    logic                       cfg_wr;
    logic                       accept;
    logic                       out_free;
    logic [POS_W-1:0]           step_cnt;
    logic                       step_dir;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_TIME_DELTA);
    assign prdata   = (paddr[2] == REG_TIME_DELTA) ? PDATA_W'(r_time_delta) : '0;

    assign win_len  = (r_time_delta == '0) ? WIN_W'(1) : r_time_delta;
    assign elapsed  = i_in.now_ms - r_win_start;
    assign w_diff   = $signed({r_pos_new[POS_W-1], r_pos_new})
                    - $signed({r_pos_old[POS_W-1], r_pos_old});
    assign prod_mag = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
    assign rem_sh   = {r_rem, r_acc[MAG_W-1]};
    assign trial    = {1'b0, rem_sh} - {2'b00, r_div};

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_res.ready;

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_res.valid    = r_out_valid;
    assign o_res.position = $signed(r_out_pos);
    assign o_res.clockwise = r_out_cw;
    assign o_res.speed    = $signed(r_out_speed);

    always_comb begin
        step_cnt = r_cnt;
        step_dir = r_dir;
        if (i_in.pin_a != r_prev_a) begin
            if (i_in.pin_b != i_in.pin_a) begin
                step_dir = 1'b0;
                step_cnt = r_cnt - POS_W'(1);
            end else begin
                step_dir = 1'b1;
                step_cnt = r_cnt + POS_W'(1);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_prev_a    = r_prev_a;
        n_dir       = r_dir;
        n_win_start = r_win_start;
        n_pos_old   = r_pos_old;
        n_pos_new   = r_pos_new;
        n_rate      = r_rate;
        n_prod      = r_prod;
        n_neg       = r_neg;
        n_acc       = r_acc;
        n_rem       = r_rem;
        n_div       = r_div;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        n_out_pos   = r_out_pos;
        n_out_cw    = r_out_cw;
        n_out_speed = r_out_speed;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_HOLD;
                    if (i_in.op == OP_CLEAR) begin
                        n_cnt    = '0;
                        n_prev_a = 1'b0;
                        n_dir    = 1'b0;
                    end else begin
                        n_cnt    = step_cnt;
                        n_dir    = step_dir;
                        n_prev_a = i_in.pin_a;
                        if (elapsed >= TIME_W'(win_len)) begin
                            n_win_start = i_in.now_ms;
                            n_pos_old   = r_pos_new;
                            n_pos_new   = step_cnt;
                            n_state     = S_MUL;
                        end
                    end
                end
            end
            S_MUL: begin
                n_prod  = PROD_W'(w_diff) * PROD_W'(SPEED_SCALE)
                        + $signed(PROD_W'(win_len));
                n_div   = {win_len, 1'b0};
                n_state = S_ABS;
            end
            S_ABS: begin
                n_neg   = r_prod[PROD_W-1];
                n_acc   = prod_mag[MAG_W-1:0];
                n_rem   = '0;
                n_step  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_acc  = {r_acc[MAG_W-2:0], !trial[DIV_W+1]};
                n_rem  = trial[DIV_W+1] ? rem_sh[DIV_W-1:0] : trial[DIV_W-1:0];
                n_step = r_step + STEP_W'(1);
                if (r_step == DIV_LAST) begin
                    n_state = S_SAT;
                end
            end
            S_SAT: begin
                if (!r_neg) begin
                    if (r_acc[MAG_W-1:SPEED_W-1] != '0) begin
                        n_rate = {1'b0, {(SPEED_W-1){1'b1}}};
                    end else begin
                        n_rate = r_acc[SPEED_W-1:0];
                    end
                end else begin
                    if ((r_acc[MAG_W-1:SPEED_W] != '0)
                        || (r_acc[SPEED_W-1] && (r_acc[SPEED_W-2:0] != '0))) begin
                        n_rate = {1'b1, {(SPEED_W-1){1'b0}}};
                    end else begin
                        n_rate = -r_acc[SPEED_W-1:0];
                    end
                end
                n_state = S_HOLD;
            end
            S_HOLD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_pos   = r_cnt;
                    n_out_cw    = r_dir;
                    n_out_speed = r_rate;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_time_delta <= TIME_DELTA_RST;
            r_cnt        <= '0;
            r_prev_a     <= 1'b0;
            r_dir        <= 1'b0;
            r_win_start  <= '0;
            r_pos_old    <= '0;
            r_pos_new    <= '0;
            r_rate       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            if (cfg_wr) begin
                r_time_delta <= pwdata[WIN_W-1:0];
            end
            r_cnt        <= n_cnt;
            r_prev_a     <= n_prev_a;
            r_dir        <= n_dir;
            r_win_start  <= n_win_start;
            r_pos_old    <= n_pos_old;
            r_pos_new    <= n_pos_new;
            r_rate       <= n_rate;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod      <= n_prod;
        r_neg       <= n_neg;
        r_acc       <= n_acc;
        r_rem       <= n_rem;
        r_div       <= n_div;
        r_step      <= n_step;
        r_out_pos   <= n_out_pos;
        r_out_cw    <= n_out_cw;
        r_out_speed <= n_out_speed;
    end

`ifndef SYNTHESIS
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_in.ready)
        else $error("input ready while an item is in progress");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_div))
        else $error("divider remainder out of range");

    a_clear_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in.op == OP_CLEAR)) |=> (r_cnt == '0) && !r_prev_a && !r_dir)
        else $error("clear item left count or direction set");

    a_pos_speed_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SAT && !r_neg) |=> !r_rate[SPEED_W-1])
        else $error("non-negative quotient gave negative speed");
`endif

endmodule
